>>> rtl/core/ucc_pkg.sv
package ucc_pkg;

    // Shared adder width
    localparam int ALU_W = 32;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
    localparam logic [4:0]  EPOCH_MOD25 = 5'd20;      // 1970 mod 25
    localparam logic [4:0]  MOD25_LAST  = 5'd24;
    localparam logic [8:0]  DAYS_LEAP   = 9'd366;
    localparam logic [8:0]  DAYS_NORM   = 9'd365;
    localparam logic [3:0]  MONTHS      = 4'd12;

    // Time constants
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [5:0]  DIV_60       = 6'd60;
    localparam logic [5:0]  DIV_24       = 6'd24;

    // floor(t / 60) == (t * RECIP_60) >> SHIFT_60 and
    // floor(t / 24) == (t * RECIP_24) >> SHIFT_24 for any 32-bit t
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int          SHIFT_60 = 37;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam int          SHIFT_24 = 36;

    // floor(y / 25) == (y * RECIP_25) >> RECIP_SHIFT for any 12-bit y
    localparam logic [15:0] RECIP_25    = 16'd41944;
    localparam int          RECIP_SHIFT = 20;
    localparam logic [12:0] MUL_25      = 13'd25;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAP_Q,
        S_LEAP_R,
        S_YEAR_ADD,
        S_MONTH_ADD,
        S_DAY_ADD,
        S_MUL,
        S_DIV_S,
        S_DIV_M,
        S_DIV_H,
        S_YEAR_SUB,
        S_MONTH_SUB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        action;
        logic [31:0] seconds;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } req_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic        wrapped;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } res_t;

    // 4/100/400 rule from the low year bits and a divisible-by-25 flag
    function automatic logic is_leap(input logic [3:0] y_lo, input logic div25);
        return (y_lo[1:0] == 2'd0) && (!div25 || (y_lo == 4'd0));
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? DAYS_LEAP : DAYS_NORM;
    endfunction

    // Month index from 0 = January
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/ucc_alu.sv
module ucc_alu (
    input  logic [ucc_pkg::ALU_W-1:0] a,
    input  logic [ucc_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [ucc_pkg::ALU_W-1:0] sum,
    output logic                      carry
);

    logic [ucc_pkg::ALU_W:0] full;

    // a + b, or a - b with carry meaning no borrow (a >= b)
    assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ucc_pkg::ALU_W{1'b0}}, sub};
    assign sum   = full[ucc_pkg::ALU_W-1:0];
    assign carry = full[ucc_pkg::ALU_W];

endmodule

>>> rtl/core/ucc_core.sv
module ucc_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ucc_pkg::req_t req,
    input  logic          res_take,
    output logic          idle,
    output logic          done,
    output ucc_pkg::res_t res
);

    ucc_pkg::state_t state_reg, state_next;

    // Control registers
    logic        phase_reg, phase_next;
    logic [4:0]  c25_reg, c25_next;
    logic [3:0]  m_reg, m_next;

    // Payload registers
    logic        act_reg, act_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] acc_reg, acc_next;
    logic [11:0] yin_reg, yin_next;
    logic [3:0]  full_reg, full_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [11:0] year_reg, year_next;
    logic [7:0]  q25_reg, q25_next;
    logic [17:0] hms_reg, hms_next;
    logic        leapin_reg, leapin_next;
    logic [39:0] total_reg, total_next;

    // Shared adder
    logic [ucc_pkg::ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic                      alu_sub, alu_carry;

    // Helpers
    logic [31:0] recip;
    logic [63:0] div_prod;
    logic [31:0] div_q;
    logic [5:0]  divisor;
    logic [5:0]  rem_prod;
    logic        yleap;
    logic [4:0]  c25_inc;
    logic [27:0] q25_prod;
    logic [12:0] mult25;
    logic [16:0] hms_sum;
    logic [36:0] day_prod;

    ucc_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Fixed-function side logic
    assign recip    = (state_reg == ucc_pkg::S_DIV_H) ? ucc_pkg::RECIP_24 : ucc_pkg::RECIP_60;
    assign div_prod = {32'd0, quo_reg} * {32'd0, recip};
    assign div_q    = (state_reg == ucc_pkg::S_DIV_H) ?
                      {4'd0, div_prod[63:ucc_pkg::SHIFT_24]} :
                      {5'd0, div_prod[63:ucc_pkg::SHIFT_60]};
    assign divisor  = (state_reg == ucc_pkg::S_DIV_H) ? ucc_pkg::DIV_24 : ucc_pkg::DIV_60;
    // remainder is below 64, so the low six bits of quotient * divisor do
    assign rem_prod = acc_reg[5:0] * divisor;
    assign yleap    = ucc_pkg::is_leap(year_reg[3:0], c25_reg == 5'd0);
    assign c25_inc  = (c25_reg == ucc_pkg::MOD25_LAST) ? 5'd0 : c25_reg + 5'd1;
    assign q25_prod = yin_reg * ucc_pkg::RECIP_25;
    assign mult25   = {5'd0, q25_reg} * ucc_pkg::MUL_25;
    assign hms_sum  = {12'd0, hour_reg} * ucc_pkg::SEC_PER_HOUR
                    + {11'd0, min_reg} * ucc_pkg::SEC_PER_MIN
                    + {11'd0, sec_reg};
    assign day_prod = {17'd0, acc_reg[19:0]} * {20'd0, ucc_pkg::SEC_PER_DAY};

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        c25_next    = c25_reg;
        m_next      = m_reg;
        act_next    = act_reg;
        quo_next    = quo_reg;
        acc_next    = acc_reg;
        yin_next    = yin_reg;
        full_next   = full_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        year_next   = year_reg;
        q25_next    = q25_reg;
        hms_next    = hms_reg;
        leapin_next = leapin_reg;
        total_next  = total_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (state_reg)
            ucc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next   = req.action;
                    quo_next   = req.seconds;
                    yin_next   = req.year;
                    day_next   = req.day;
                    hour_next  = req.hour;
                    min_next   = req.minute;
                    sec_next   = req.second;
                    phase_next = 1'b0;
                    acc_next   = '0;
                    m_next     = '0;
                    year_next  = ucc_pkg::EPOCH_YEAR;
                    c25_next   = ucc_pkg::EPOCH_MOD25;
                    // whole months before the given one, capped at a full year
                    if (req.month == 4'd0)
                        full_next = 4'd0;
                    else if (req.month > ucc_pkg::MONTHS + 4'd1)
                        full_next = ucc_pkg::MONTHS;
                    else
                        full_next = req.month - 4'd1;
                    state_next = req.action ? ucc_pkg::S_DIV_S : ucc_pkg::S_LEAP_Q;
                end
            end

            ucc_pkg::S_LEAP_Q:
            begin
                q25_next   = q25_prod[27:ucc_pkg::RECIP_SHIFT];
                // time of day less one day: folds the day-1 term in
                hms_next   = {1'b0, hms_sum} - {1'b0, ucc_pkg::SEC_PER_DAY};
                state_next = ucc_pkg::S_LEAP_R;
            end

            ucc_pkg::S_LEAP_R:
            begin
                leapin_next = ucc_pkg::is_leap(yin_reg[3:0], mult25 == {1'b0, yin_reg});
                state_next  = ucc_pkg::S_YEAR_ADD;
            end

            ucc_pkg::S_YEAR_ADD:
            begin
                if (year_reg < yin_reg)
                begin
                    alu_a     = acc_reg;
                    alu_b     = {23'd0, ucc_pkg::year_len(yleap)};
                    acc_next  = alu_sum;
                    year_next = year_reg + 12'd1;
                    c25_next  = c25_inc;
                end
                else
                begin
                    state_next = ucc_pkg::S_MONTH_ADD;
                end
            end

            ucc_pkg::S_MONTH_ADD:
            begin
                if (m_reg < full_reg)
                begin
                    alu_a    = acc_reg;
                    alu_b    = {27'd0, ucc_pkg::month_len(m_reg, leapin_reg)};
                    acc_next = alu_sum;
                    m_next   = m_reg + 4'd1;
                end
                else
                begin
                    state_next = ucc_pkg::S_DAY_ADD;
                end
            end

            ucc_pkg::S_DAY_ADD:
            begin
                alu_a      = acc_reg;
                alu_b      = {27'd0, day_reg};
                acc_next   = alu_sum;
                state_next = ucc_pkg::S_MUL;
            end

            ucc_pkg::S_MUL:
            begin
                total_next = {3'd0, day_prod} + {{22{hms_reg[17]}}, hms_reg};
                state_next = ucc_pkg::S_DONE;
            end

            // Divide by a constant: reciprocal multiply for the quotient, then the
            // remainder on the shared adder
            ucc_pkg::S_DIV_S, ucc_pkg::S_DIV_M, ucc_pkg::S_DIV_H:
            begin
                if (!phase_reg)
                begin
                    acc_next   = div_q;
                    phase_next = 1'b1;
                end
                else
                begin
                    alu_a      = {26'd0, quo_reg[5:0]};
                    alu_b      = {26'd0, rem_prod};
                    alu_sub    = 1'b1;
                    quo_next   = acc_reg;
                    phase_next = 1'b0;
                    if (state_reg == ucc_pkg::S_DIV_S)
                    begin
                        sec_next   = alu_sum[5:0];
                        state_next = ucc_pkg::S_DIV_M;
                    end
                    else if (state_reg == ucc_pkg::S_DIV_M)
                    begin
                        min_next   = alu_sum[5:0];
                        state_next = ucc_pkg::S_DIV_H;
                    end
                    else
                    begin
                        // quotient left in acc is the day count
                        hour_next  = alu_sum[4:0];
                        state_next = ucc_pkg::S_YEAR_SUB;
                    end
                end
            end

            ucc_pkg::S_YEAR_SUB:
            begin
                alu_a   = acc_reg;
                alu_b   = {23'd0, ucc_pkg::year_len(yleap)};
                alu_sub = 1'b1;
                if (alu_carry)
                begin
                    acc_next  = alu_sum;
                    year_next = year_reg + 12'd1;
                    c25_next  = c25_inc;
                end
                else
                begin
                    m_next     = 4'd1;
                    state_next = ucc_pkg::S_MONTH_SUB;
                end
            end

            ucc_pkg::S_MONTH_SUB:
            begin
                alu_a   = acc_reg;
                alu_b   = {27'd0, ucc_pkg::month_len(m_reg - 4'd1, yleap)};
                alu_sub = 1'b1;
                if ((m_reg < ucc_pkg::MONTHS) && alu_carry)
                begin
                    acc_next = alu_sum;
                    m_next   = m_reg + 4'd1;
                end
                else
                begin
                    state_next = ucc_pkg::S_DONE;
                end
            end

            ucc_pkg::S_DONE:
            begin
                if (res_take)
                    state_next = ucc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = ucc_pkg::S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ucc_pkg::S_IDLE;
            phase_reg <= 1'b0;
            c25_reg   <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            c25_reg   <= c25_next;
            m_reg     <= m_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        quo_reg    <= quo_next;
        acc_reg    <= acc_next;
        yin_reg    <= yin_next;
        full_reg   <= full_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        year_reg   <= year_next;
        q25_reg    <= q25_next;
        hms_reg    <= hms_next;
        leapin_reg <= leapin_next;
        total_reg  <= total_next;
    end

    // Result formatting: unused direction reads as zero
    assign idle = (state_reg == ucc_pkg::S_IDLE);
    assign done = (state_reg == ucc_pkg::S_DONE);

    always_comb
    begin
        res.seconds = act_reg ? 32'd0 : total_reg[31:0];
        res.wrapped = act_reg ? 1'b0 : (|total_reg[39:32]);
        res.year    = act_reg ? year_reg : 12'd0;
        res.month   = act_reg ? m_reg : 4'd0;
        res.day     = act_reg ? (acc_reg[4:0] + 5'd1) : 5'd0;
        res.hour    = act_reg ? hour_reg : 5'd0;
        res.minute  = act_reg ? min_reg : 6'd0;
        res.second  = act_reg ? sec_reg : 6'd0;
    end

`ifndef NO_ASSERTIONS
    a_phase_div: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> ((state_reg == ucc_pkg::S_DIV_S) || (state_reg == ucc_pkg::S_DIV_M) ||
                       (state_reg == ucc_pkg::S_DIV_H)))
        else $error("divider phase set outside a divide");

    a_c25_range: assert property (@(posedge clk) disable iff (!rst_n)
        c25_reg <= ucc_pkg::MOD25_LAST)
        else $error("mod-25 year counter out of range");

    a_year_add: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ucc_pkg::S_YEAR_ADD) && (yin_reg >= ucc_pkg::EPOCH_YEAR))
            |-> (year_reg <= yin_reg))
        else $error("year count ran past the requested year");

    a_month_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ucc_pkg::S_MONTH_ADD) |-> (m_reg <= full_reg))
        else $error("month count ran past the whole months");

    a_month_sub: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ucc_pkg::S_MONTH_SUB) |->
            ((m_reg >= 4'd1) && (m_reg <= ucc_pkg::MONTHS)))
        else $error("month index out of range while peeling months");
`endif

endmodule

>>> rtl/core/unix_time_calendar_convert_unit.sv
// Seconds to date: three reciprocal divides (seconds, minutes, hours), then whole years
// and whole months are peeled off the day count before out_valid.
// Date to seconds: leap check, then the years since 1970, whole months and the day are
// summed and scaled to seconds. One item at a time: the next is taken once the result has
// moved into the output register.
// Reset (rst_n, async, active low) idles the sequencer and empties the output register.
module unix_time_calendar_convert_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] seconds_in,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [4:0]  hour_in,
    input  logic [5:0]  minute_in,
    input  logic [5:0]  second_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seconds_out,
    output logic        wrapped,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out
);

    ucc_pkg::req_t req;
    ucc_pkg::res_t core_res;
    ucc_pkg::res_t res_reg;
    logic          out_valid_reg;
    logic          core_idle;
    logic          core_done;
    logic          res_take;
    logic          start;

    // Input transfer
    assign in_ready = core_idle;
    assign start    = in_valid && core_idle;

    assign req.action  = action;
    assign req.seconds = seconds_in;
    assign req.year    = year_in;
    assign req.month   = month_in;
    assign req.day     = day_in;
    assign req.hour    = hour_in;
    assign req.minute  = minute_in;
    assign req.second  = second_in;

    ucc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .res_take (res_take),
        .idle     (core_idle),
        .done     (core_done),
        .res      (core_res)
    );

    // Output register: loads when empty or being drained
    assign res_take = core_done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            res_reg <= core_res;
    end

    assign out_valid   = out_valid_reg;
    assign seconds_out = res_reg.seconds;
    assign wrapped     = res_reg.wrapped;
    assign year_out    = res_reg.year;
    assign month_out   = res_reg.month;
    assign day_out     = res_reg.day;
    assign hour_out    = res_reg.hour;
    assign minute_out  = res_reg.minute;
    assign second_out  = res_reg.second;

endmodule
